>>> rtl/core/tst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types and constants for the streaming top-K minimum tracker.
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam int DIST_W       = 16;
  localparam int IDX_W        = 16;
  localparam int POS_W        = 6;
  localparam int KEEP_DEFAULT = 5;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 40;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  idx;
  } entry_t;

  // handed from one cell to the next every cycle
  typedef struct packed {
    entry_t entry;
    logic   ins_before;  // candidate ranks ahead of this cell's entry
  } link_t;

  localparam entry_t ENTRY_CLEAR = '{distance: DIST_MAX, idx: '0};

endpackage

>>> rtl/core/topk_smallest_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topk_smallest_tracker_core
// Streaming tracker of the KEEP_COUNT smallest distances with their indices.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one candidate per transfer: tdata = distance, index;
//   tlast marks the final candidate of a search.
//   m_axis returns KEEP_COUNT results after each final candidate, rank 0
//   first: tdata = distance, index, rank; tlast on the last rank.
// Throughput: one candidate per cycle, but for a held-off final candidate;
//   a row of KEEP_COUNT compare/shift cells inserts each candidate.
// Output: rank 0 is valid the cycle after the final candidate's transfer;
//   the run drains at one rank per cycle through the snapshot chain.
// A final candidate is held off (tready low) while an earlier run is still
//   draining; plain candidates keep flowing. A stalled m_axis only delays
//   the drain.
// Reset: store cleared to maximum distance / index 0, no run pending.
// ----------------------------------------------------------------------------
module topk_smallest_tracker_core #(
  parameter int KEEP_COUNT = tst_pkg::KEEP_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tst_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // cand_distance, cand_index
  input  logic                           s_axis_tlast,  // end_of_search
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [tst_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // rank_distance, rank_index,
                                                        // rank_position, 2'b0
  output logic                           m_axis_tlast   // last_rank
);

  import tst_pkg::*;

  entry_t cand;
  logic   ins;
  logic   ins_last;
  logic   shift;
  logic   busy;
  logic [POS_W-1:0] pos;
  logic   at_last;

  link_t  link [KEEP_COUNT];
  entry_t snap [KEEP_COUNT];

  assign cand.distance = s_axis_tdata[DIST_W-1:0];
  assign cand.idx      = s_axis_tdata[DIST_W +: IDX_W];

  assign s_axis_tready = !(busy && s_axis_tlast);
  assign ins      = s_axis_tvalid && s_axis_tready;
  assign ins_last = ins && s_axis_tlast;
  assign shift    = m_axis_tvalid && m_axis_tready;
  assign at_last  = pos == POS_W'(KEEP_COUNT - 1);

  genvar g;
  generate
    for (g = 0; g < KEEP_COUNT; g++) begin : g_cell
      link_t  prev;
      entry_t snap_in;
      if (g == 0) begin : g_head
        assign prev = '{entry: ENTRY_CLEAR, ins_before: 1'b0};
      end else begin : g_body
        assign prev = link[g-1];
      end
      if (g == KEEP_COUNT - 1) begin : g_tail
        assign snap_in = ENTRY_CLEAR;
      end else begin : g_mid
        assign snap_in = snap[g+1];
      end
      tst_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cand     (cand),
        .ins      (ins),
        .ins_last (ins_last),
        .prev     (prev),
        .link     (link[g]),
        .shift    (shift),
        .snap_in  (snap_in),
        .snap     (snap[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (ins_last) begin
      busy <= 1'b1;
      pos  <= '0;
    end else if (shift) begin
      if (at_last) begin
        busy <= 1'b0;
      end
      pos <= pos + POS_W'(1);
    end
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = {2'b00, pos, snap[0].idx, snap[0].distance};
  assign m_axis_tlast  = at_last;

  a_final_starts_run: assert property (@(posedge clk) disable iff (rst)
    ins_last |=> (m_axis_tvalid && pos == '0))
    else $error("final candidate did not start an output run");

  a_run_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    (shift && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("output run continued past last rank");

  a_rank_in_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (pos <= POS_W'(KEEP_COUNT - 1)))
    else $error("rank position out of range");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    busy |-> !ins_last)
    else $error("final candidate taken while a run is draining");

endmodule

>>> rtl/core/tst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_cell
// One rank of the kept list: compare, take from neighbor or candidate, and
// one stage of the output drain chain.
// ----------------------------------------------------------------------------
module tst_cell (
  input  logic           clk,
  input  logic           rst,
  input  tst_pkg::entry_t cand,
  input  logic           ins,
  input  logic           ins_last,
  input  tst_pkg::link_t prev,
  output tst_pkg::link_t link,
  input  logic           shift,
  input  tst_pkg::entry_t snap_in,
  output tst_pkg::entry_t snap
);

  import tst_pkg::*;

  entry_t kept;
  entry_t kept_next;
  logic   lt;

  assign lt = cand.distance < kept.distance;

  always_comb begin
    if (prev.ins_before) begin
      kept_next = prev.entry;
    end else if (lt) begin
      kept_next = cand;
    end else begin
      kept_next = kept;
    end
  end

  assign link.entry      = kept;
  assign link.ins_before = lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      kept <= ENTRY_CLEAR;
    end else if (ins && ins_last) begin
      kept <= ENTRY_CLEAR;
    end else if (ins) begin
      kept <= kept_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ins && ins_last) begin
      snap <= kept_next;
    end else if (shift) begin
      snap <= snap_in;
    end
  end

endmodule

>>> verif/topk_rank_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topk_rank_checker
// Watches both stream channels of the top-K tracker, keeps its own sorted
// copy of the K best candidates, and compares every ranked result against it.
// ----------------------------------------------------------------------------
module topk_rank_checker #(
  parameter int KEEP = tst_pkg::KEEP_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cand_tvalid,
  input  logic                           cand_tready,
  input  logic [tst_pkg::IN_DATA_W-1:0]  cand_tdata,   // cand_distance, cand_index
  input  logic                           cand_tlast,   // end_of_search
  input  logic                           rank_tvalid,
  input  logic                           rank_tready,
  input  logic [tst_pkg::OUT_DATA_W-1:0] rank_tdata,   // rank_distance, rank_index,
                                                       // rank_position, 2'b0
  input  logic                           rank_tlast,   // last_rank
  output int                             error_count,
  output int                             pending
);

  import tst_pkg::*;

  localparam int PAD_LO = DIST_W + IDX_W + POS_W;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  idx;
    logic [POS_W-1:0]  pos;
    logic              last;
  } rank_t;

  entry_t kept [KEEP];
  rank_t  expected_ranks [$];

  initial begin
    error_count = 0;
    pending     = 0;
  end

  task automatic report_mismatch(input string what);
    if (error_count < 40) $display("%0t ns rank check: %s", $time, what);
    error_count++;
  endtask

  task automatic clear_kept();
    foreach (kept[r]) kept[r] = ENTRY_CLEAR;
  endtask

  // newcomer goes behind every kept entry of equal or smaller distance
  task automatic place_candidate(input entry_t cand);
    int slot;
    slot = 0;
    while (slot < KEEP && kept[slot].distance <= cand.distance) slot++;
    if (slot < KEEP) begin
      for (int r = KEEP - 1; r > slot; r--) kept[r] = kept[r-1];
      kept[slot] = cand;
    end
  endtask

  always @(posedge clk) begin
    rank_t  got;
    rank_t  want;
    entry_t cand;
    if (rst) begin
      clear_kept();
      expected_ranks.delete();
    end else begin
      if (rank_tvalid && rank_tready) begin
        got.distance = rank_tdata[DIST_W-1:0];
        got.idx      = rank_tdata[DIST_W+IDX_W-1:DIST_W];
        got.pos      = rank_tdata[PAD_LO-1:DIST_W+IDX_W];
        got.last     = rank_tlast;
        if (rank_tdata[OUT_DATA_W-1:PAD_LO] != '0)
          report_mismatch($sformatf("pad bits set: %h", rank_tdata));
        if (expected_ranks.size() == 0) begin
          report_mismatch($sformatf("unexpected result rank %0d dist %0d idx %0d",
                                    got.pos, got.distance, got.idx));
        end else begin
          want = expected_ranks.pop_front();
          if (got.distance != want.distance || got.idx != want.idx ||
              got.pos != want.pos || got.last != want.last)
            report_mismatch($sformatf(
              "got rank %0d dist %0d idx %0d last %0b, want rank %0d dist %0d idx %0d last %0b",
              got.pos, got.distance, got.idx, got.last,
              want.pos, want.distance, want.idx, want.last));
        end
      end
      if (cand_tvalid && cand_tready) begin
        cand.distance = cand_tdata[DIST_W-1:0];
        cand.idx      = cand_tdata[DIST_W+IDX_W-1:DIST_W];
        place_candidate(cand);
        if (cand_tlast) begin
          for (int r = 0; r < KEEP; r++) begin
            want.distance = kept[r].distance;
            want.idx      = kept[r].idx;
            want.pos      = POS_W'(r);
            want.last     = (r == KEEP - 1);
            expected_ranks.push_back(want);
          end
          clear_kept();
        end
      end
    end
    pending <= expected_ranks.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for topk_smallest_tracker_core: directed searches
// (empty, short, ties, maximum distance, rejected candidates), then random
// searches with random idling on both sides, a long result stall and a
// full drain pause. Checking is done by topk_rank_checker.
// ----------------------------------------------------------------------------
module testbench;
  import tst_pkg::*;

  localparam int KEEP         = KEEP_DEFAULT;
  localparam int RANDOM_ITEMS = 190;
  localparam int CALM_LO      = 110;
  localparam int CALM_HI      = 150;
  localparam int HOLD_AT      = 30;
  localparam int HOLD_CYCLES  = 90;
  localparam int CYCLE_LIMIT  = 40000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  logic calm = 1'b0;
  int   error_count;
  int   pending;
  int   cand_count = 0;
  int   search_count = 0;
  int   rank_count = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   cycle_count = 0;
  int   directed_count;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  topk_smallest_tracker_core #(.KEEP_COUNT(KEEP)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  topk_rank_checker #(.KEEP(KEEP)) rank_check (
    .clk         (clk),
    .rst         (rst),
    .cand_tvalid (s_tvalid),
    .cand_tready (s_tready),
    .cand_tdata  (s_tdata),
    .cand_tlast  (s_tlast),
    .rank_tvalid (m_tvalid),
    .rank_tready (m_tready),
    .rank_tdata  (m_tdata),
    .rank_tlast  (m_tlast),
    .error_count (error_count),
    .pending     (pending)
  );

  // result side: random backpressure, one long hold-off, calm window
  always @(posedge clk) begin
    if (m_tvalid && m_tready) rank_count <= rank_count + 1;
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && rank_count >= HOLD_AT) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: timeout after %0d cycles, %0d results pending",
               cycle_count, pending);
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic offer_candidate(input logic [DIST_W-1:0] cand_dist,
                                 input logic [IDX_W-1:0] idx, input logic final_cand);
    bit calm_now;
    calm_now = (cand_count >= CALM_LO && cand_count < CALM_HI);
    calm <= calm_now;
    while (!calm_now && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {idx, cand_dist};
    s_tlast  <= final_cand;
    do @(posedge clk); while (!s_tready);
    cand_count++;
    if (final_cand) search_count++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int                run_len;
    int                style;
    logic [DIST_W-1:0] cand_dist;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty search, lone maximum-distance candidate
    offer_candidate(DIST_MAX, 16'hFFFF, 1'b1);
    // fewer candidates than ranks, tie at zero
    offer_candidate(16'd0, 16'hFFFF, 1'b0);
    offer_candidate(16'd100, 16'd1, 1'b0);
    offer_candidate(16'd0, 16'd2, 1'b1);
    // descending fill, reject, max distance, tie, new front, rejected final
    offer_candidate(16'd50, 16'd10, 1'b0);
    offer_candidate(16'd40, 16'd11, 1'b0);
    offer_candidate(16'd30, 16'd12, 1'b0);
    offer_candidate(16'd20, 16'd13, 1'b0);
    offer_candidate(16'd10, 16'd14, 1'b0);
    offer_candidate(16'd60, 16'd15, 1'b0);
    offer_candidate(DIST_MAX, 16'd16, 1'b0);
    offer_candidate(16'd20, 16'd17, 1'b0);
    offer_candidate(16'd5, 16'd18, 1'b0);
    offer_candidate(16'hFFFE, 16'd19, 1'b1);
    // ascending fill, final ties the last rank
    for (int n = 0; n < KEEP; n++) offer_candidate(DIST_W'(n + 1), IDX_W'(20 + n), 1'b0);
    offer_candidate(DIST_W'(KEEP), 16'd25, 1'b1);
    directed_count = cand_count;
    drain_results();

    while (cand_count < directed_count + RANDOM_ITEMS) begin
      run_len = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
      style   = $urandom_range(2);
      if (search_count == 16) drain_results();
      for (int n = 0; n < run_len; n++) begin
        case (style)
          0: cand_dist = DIST_W'($urandom_range(7));
          1: cand_dist = DIST_W'($urandom);
          default: begin
            case ($urandom_range(4))
              0: cand_dist = '0;
              1: cand_dist = DIST_MAX;
              2: cand_dist = 16'd1;
              3: cand_dist = DIST_MAX - 16'd1;
              default: cand_dist = DIST_W'($urandom);
            endcase
          end
        endcase
        offer_candidate(cand_dist, IDX_W'($urandom), n == run_len - 1);
      end
    end

    drain_results();
    repeat (4 * KEEP + 10) @(posedge clk);
    $display("testbench: %0d candidates in %0d searches, %0d ranked results compared",
             cand_count, search_count, rank_count);
    $display("testbench: ties, rejects, max distance, %0d-cycle result stall, drain pauses",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
